// ===== src/rsra_pkg.sv =====
package rsra_pkg;

  // built maximum of the segment ring
  localparam int unsigned MaxSegmentsDefault = 64;

  // command codes
  localparam logic [1:0] CmdAlloc   = 2'd0;
  localparam logic [1:0] CmdRelease = 2'd1;
  localparam logic [1:0] CmdClear   = 2'd2;

  // status codes
  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatNoFree  = 2'd1;
  localparam logic [1:0] StatBadRel  = 2'd2;

  // register indexes and reset values
  localparam logic RegSegSize  = 1'b0;
  localparam logic RegSegCount = 1'b1;
  localparam logic [29:0] SegSizeReset  = 30'd67108864;
  localparam logic [6:0]  SegCountReset = 7'd64;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] required_size;
    logic [5:0]  release_segment;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  segment;
    logic [39:0] offset;
    logic [45:0] bytes_in_use;
  } out_item_t;

  // one entry of the segment table
  typedef struct packed {
    logic [39:0] offset;
    logic [31:0] refs;
  } seg_entry_t;

  typedef enum logic [2:0] {
    StIdle,
    StMod,
    StRead,
    StEval,
    StScan,
    StResp
  } state_e;

endpackage

// ===== src/refcounted_segment_ring_allocator.sv =====
// channel   | direction | handshake               | payload
// in        | input     | in_valid_i / in_ready_o | in_data_i  (cmd, required_size, release_segment)
// out       | output    | out_valid_o/out_ready_i | out_data_o (status, segment, offset, bytes_in_use)
// config    | input     | psel, penable, pwrite   | paddr, pwdata, prdata (pready tied high)
//
// allocate that fits in place: result passes through the mod, read, eval and resp states
// allocate that scans: the scan state checks candidates in turn, up to the used segment count
// a current segment left beyond a shrunk count is brought back by repeated subtracts of the count in mod
// release: read, eval and resp states, straight to resp when past the count; clear and unknown commands: resp only
// input is taken only in idle, so the next transfer comes in the cycle after the result is loaded
// reset and the clear command empty the table at once through the per-segment busy flags
// a waiting result sits in the output register; the next item is taken meanwhile and only
// its own result waits in the resp state until the output register frees up
module refcounted_segment_ring_allocator
  import rsra_pkg::*;
#(
  parameter int unsigned MaxSegments = MaxSegmentsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // index width and count width (count can equal MaxSegments)
  localparam int unsigned IW   = (MaxSegments > 1) ? $clog2(MaxSegments) : 1;
  localparam int unsigned CW   = $clog2(MaxSegments + 1);
  localparam int unsigned CMPW = (CW > 7) ? CW : 7;
  localparam int unsigned RW   = (CW > 6) ? CW : 6;

  // configuration registers
  logic [29:0] seg_size_q;
  logic [6:0]  seg_count_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_size_q  <= SegSizeReset;
      seg_count_q <= SegCountReset;
    end else if (cfg_wr) begin
      case (paddr[2])
        RegSegSize:  seg_size_q  <= pwdata[29:0];
        RegSegCount: seg_count_q <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegSegSize:  prdata = {2'b0, seg_size_q};
      RegSegCount: prdata = {25'b0, seg_count_q};
      default:     prdata = '0;
    endcase
  end

  // used count: zero acts as one, above the built maximum clamps
  logic [CMPW-1:0] sc_ext;
  logic [CW-1:0]   count;

  assign sc_ext = CMPW'(seg_count_q);

  always_comb begin
    if (sc_ext == '0) begin
      count = CW'(1);
    end else if (sc_ext > CMPW'(MaxSegments)) begin
      count = CW'(MaxSegments);
    end else begin
      count = CW'(sc_ext);
    end
  end

  // control and status state
  state_e            state_q, state_d;
  logic [MaxSegments-1:0] busy_q, busy_d;  // ref count nonzero; a clear entry reads as zero
  logic [IW-1:0]     current_q, current_d;
  logic [45:0]       total_q, total_d;
  logic [IW-1:0]     cur_q, cur_d;
  logic [IW-1:0]     cand_q, cand_d;
  logic [CW-1:0]     steps_q, steps_d;
  logic              out_valid_q, out_valid_d;

  // payload registers
  in_item_t          item_q, item_d;
  logic [1:0]        res_status_q, res_status_d;
  logic [5:0]        res_seg_q, res_seg_d;
  logic [39:0]       res_off_q, res_off_d;
  out_item_t         out_q, out_d;

  // table memory port
  logic              mem_we, mem_re;
  logic [IW-1:0]     mem_waddr, mem_raddr;
  seg_entry_t        mem_wdata, mem_rdata;

  rsra_seg_mem #(
    .Depth (MaxSegments),
    .AddrW (IW)
  ) u_seg_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // helpers for the eval and scan states
  logic [IW-1:0]  rel_idx;
  logic [IW-1:0]  eval_idx;
  seg_entry_t     entry;
  logic [40:0]    fit_sum;
  logic           fits;
  logic [CW-1:0]  cand_inc;
  logic [IW-1:0]  cand_next;
  logic           rel_out_of_range;

  assign rel_idx          = IW'(item_q.release_segment);
  assign rel_out_of_range = RW'(in_data_i.release_segment) >= RW'(count);
  assign eval_idx         = (item_q.cmd == CmdRelease) ? rel_idx : cur_q;
  assign entry            = busy_q[eval_idx] ? mem_rdata : '0;
  assign fit_sum          = {1'b0, entry.offset} + 41'(item_q.required_size);
  assign fits             = fit_sum <= 41'(seg_size_q);
  assign cand_inc         = CW'(cand_q) + CW'(1);
  assign cand_next        = (cand_inc == count) ? '0 : IW'(cand_inc);

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      busy_q      <= '0;
      current_q   <= '0;
      total_q     <= '0;
      cur_q       <= '0;
      cand_q      <= '0;
      steps_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      busy_q      <= busy_d;
      current_q   <= current_d;
      total_q     <= total_d;
      cur_q       <= cur_d;
      cand_q      <= cand_d;
      steps_q     <= steps_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    res_status_q <= res_status_d;
    res_seg_q    <= res_seg_d;
    res_off_q    <= res_off_d;
    out_q        <= out_d;
  end

  always_comb begin
    state_d      = state_q;
    busy_d       = busy_q;
    current_d    = current_q;
    total_d      = total_q;
    cur_d        = cur_q;
    cand_d       = cand_q;
    steps_d      = steps_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    item_d       = item_q;
    res_status_d = res_status_q;
    res_seg_d    = res_seg_q;
    res_off_d    = res_off_q;
    out_d        = out_q;
    mem_we       = 1'b0;
    mem_waddr    = eval_idx;
    mem_wdata    = entry;
    mem_re       = 1'b0;
    mem_raddr    = eval_idx;

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          item_d       = in_data_i;
          res_status_d = StatOk;
          res_seg_d    = '0;
          res_off_d    = '0;
          cur_d        = current_q;
          case (in_data_i.cmd)
            CmdAlloc: begin
              state_d = StMod;
            end
            CmdRelease: begin
              res_seg_d = in_data_i.release_segment;
              if (rel_out_of_range) begin
                res_status_d = StatBadRel;
                state_d      = StResp;
              end else begin
                state_d = StRead;
              end
            end
            CmdClear: begin
              busy_d    = '0;
              current_d = '0;
              total_d   = '0;
              state_d   = StResp;
            end
            default: begin
              state_d = StResp;
            end
          endcase
        end
      end

      // bring the current segment below a count that may have shrunk
      StMod: begin
        if (CW'(cur_q) >= count) begin
          cur_d = IW'(CW'(cur_q) - count);
        end else begin
          state_d = StRead;
        end
      end

      StRead: begin
        mem_re  = 1'b1;
        state_d = StEval;
      end

      StEval: begin
        state_d = StResp;
        if (item_q.cmd == CmdRelease) begin
          if (entry.refs == '0) begin
            res_status_d = StatBadRel;
          end else if (entry.refs == 32'd1) begin
            // last reference gone: the segment empties
            busy_d[rel_idx] = 1'b0;
            total_d         = total_q - 46'(entry.offset);
          end else begin
            mem_we         = 1'b1;
            mem_wdata.refs = entry.refs - 32'd1;
          end
        end else if (fits) begin
          mem_we           = 1'b1;
          mem_wdata.offset = fit_sum[39:0];
          mem_wdata.refs   = (entry.refs == '1) ? entry.refs : entry.refs + 32'd1;
          busy_d[cur_q]    = 1'b1;
          current_d        = cur_q;
          total_d          = total_q + 46'(item_q.required_size);
          res_seg_d        = 6'(cur_q);
          res_off_d        = entry.offset;
        end else begin
          cand_d  = (CW'(cur_q) + CW'(1) == count) ? '0 : IW'(CW'(cur_q) + CW'(1));
          steps_d = CW'(1);
          state_d = StScan;
        end
      end

      // round-robin search for a segment without references, ending at the current one
      StScan: begin
        if (!busy_q[cand_q]) begin
          // a free segment always holds offset zero, so nothing to subtract
          mem_we           = 1'b1;
          mem_waddr        = cand_q;
          mem_wdata.offset = 40'(item_q.required_size);
          mem_wdata.refs   = 32'd1;
          busy_d[cand_q]   = 1'b1;
          current_d        = cand_q;
          total_d          = total_q + 46'(item_q.required_size);
          res_seg_d        = 6'(cand_q);
          res_off_d        = '0;
          state_d          = StResp;
        end else if (steps_q == count) begin
          res_status_d = StatNoFree;
          state_d      = StResp;
        end else begin
          cand_d  = cand_next;
          steps_d = steps_q + CW'(1);
        end
      end

      StResp: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d        = 1'b1;
          out_d.status       = res_status_q;
          out_d.segment      = res_seg_q;
          out_d.offset       = res_off_q;
          out_d.bytes_in_use = total_q;
          state_d            = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // scan never walks past the used count
  a_scan_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (steps_q <= count) && (CW'(cand_q) < count))
    else $error("scan ran past the used segment count");

  // a table write and a table read never happen in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("table read and write in the same cycle");

  // a failed allocate reports neither a segment nor an offset
  a_nofree_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.status == StatNoFree)) |->
      (out_q.segment == '0) && (out_q.offset == '0))
    else $error("no-free result carries a placement");

  // the current segment stays a real table index
  a_current_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(current_q) < CW'(MaxSegments))
    else $error("current segment outside the table");

  // a finished item leaves the resp state only into an occupied output register
  a_resp_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StResp && state_d == StIdle) |=> out_valid_q)
    else $error("result left resp without reaching the output register");

endmodule

// ===== src/rsra_seg_mem.sv =====
module rsra_seg_mem
  import rsra_pkg::*;
#(
  parameter int unsigned Depth = MaxSegmentsDefault,
  parameter int unsigned AddrW = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  seg_entry_t       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output seg_entry_t       rdata_o
);

  seg_entry_t mem_q [Depth];
  seg_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/sv/refcounted_segment_ring_allocator_test.sv =====
module refcounted_segment_ring_allocator_test;
  import rsra_pkg::*;

  // cycles with no transfer on any port before the run is declared hung
  localparam int unsigned QuietLimit = 3000;
  // idle cycles after the last result before a register write or the end
  localparam int unsigned SettleCycles = 8;
  // random items per configuration phase
  localparam int unsigned PhaseItems = 105;

  localparam logic [2:0] AddrSegSize  = {RegSegSize, 2'b00};
  localparam logic [2:0] AddrSegCount = {RegSegCount, 2'b00};
  // the one code the command field allows beyond the defined ones
  localparam logic [1:0] CmdUnknown = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  refcounted_segment_ring_allocator #(
    .MaxSegments(MaxSegmentsDefault)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // segment table mirror: fill level and reference count per segment, the
  // current segment and the running byte total, plus the two registers
  // ---------------------------------------------------------------------------
  longint unsigned seg_fill [MaxSegmentsDefault];
  int unsigned     seg_refs [MaxSegmentsDefault];
  int unsigned     cur_seg;
  longint unsigned bytes_total;
  logic [29:0]     cfg_seg_size = SegSizeReset;
  logic [6:0]      cfg_seg_count = SegCountReset;

  in_item_t  pending_q [$];   // items waiting for the driver
  out_item_t expected_q [$];  // predicted results, oldest first

  int unsigned mismatches = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  logic        idling_on = 1'b1;

  function automatic void empty_ring();
    int unsigned idx;
    for (idx = 0; idx < MaxSegmentsDefault; idx++) begin
      seg_fill[idx] = 0;
      seg_refs[idx] = 0;
    end
    cur_seg = 0;
    bytes_total = 0;
  endfunction

  // a count of zero behaves as one, anything past the built maximum as the maximum
  function automatic int unsigned used_segments();
    if (cfg_seg_count == 0) return 1;
    if (cfg_seg_count > MaxSegmentsDefault) return MaxSegmentsDefault;
    return cfg_seg_count;
  endfunction

  // applies one command to the mirror and returns the result it must produce
  function automatic out_item_t predict_result(in_item_t item);
    out_item_t   res;
    int unsigned used, slot, start, cand, step;
    logic        found;
    res = '0;
    used = used_segments();
    case (item.cmd)
      CmdAlloc: begin
        // a current segment left past a shrunk count wraps into range
        slot = cur_seg % used;
        found = 1'b1;
        if (seg_fill[slot] + item.required_size > cfg_seg_size) begin
          // round-robin scan for an unreferenced segment, the current one last
          found = 1'b0;
          start = slot;
          for (step = 1; step <= used; step++) begin
            cand = (start + step) % used;
            if (!found && seg_refs[cand] == 0) begin
              found = 1'b1;
              bytes_total -= seg_fill[cand];
              seg_fill[cand] = 0;
              slot = cand;
            end
          end
        end
        if (found) begin
          cur_seg = slot;
          res.segment = 6'(slot);
          res.offset = 40'(seg_fill[slot]);
          seg_fill[slot] += item.required_size;
          bytes_total += item.required_size;
          if (seg_refs[slot] != 32'hFFFF_FFFF) seg_refs[slot]++;
        end else begin
          res.status = StatNoFree;
        end
      end
      CmdRelease: begin
        res.segment = item.release_segment;
        if (item.release_segment >= used || seg_refs[item.release_segment] == 0) begin
          res.status = StatBadRel;
        end else begin
          seg_refs[item.release_segment]--;
          if (seg_refs[item.release_segment] == 0) begin
            bytes_total -= seg_fill[item.release_segment];
            seg_fill[item.release_segment] = 0;
          end
        end
      end
      CmdClear: empty_ring();
      default: ;
    endcase
    res.bytes_in_use = 46'(bytes_total);
    return res;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // driver: launches queued items, keeps valid and payload steady until the
  // transfer, and records the prediction at the transfer edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) expected_q.push_back(predict_result(in_data_i));
      if (!in_valid_i || in_ready_o) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_q.pop_front();
          // a gap, when drawn, follows the transfer of this item
          if (idling_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 15);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random ready stalls, each result checked against the oldest
  // prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_item_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: %0h", out_data_o);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          check_field("status", 64'(want.status), 64'(out_data_o.status));
          check_field("segment", 64'(want.segment), 64'(out_data_o.segment));
          check_field("offset", 64'(want.offset), 64'(out_data_o.offset));
          check_field("bytes_in_use", 64'(want.bytes_in_use), 64'(out_data_o.bytes_in_use));
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (idling_on && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 15);
      end
    end
  end

  // watchdog on transfers of either channel and on register access
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  // register write: setup cycle, then access cycle; the register takes the
  // value at the edge that closes the access cycle
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == AddrSegSize) cfg_seg_size = data[29:0];
    else cfg_seg_count = data[6:0];
  endtask

  // keeps a few items ahead of the driver so targeted releases stay close
  // to the live table
  task automatic queue_item(input logic [1:0] cmd, input logic [31:0] req,
                            input logic [5:0] rel);
    in_item_t item;
    item.cmd = cmd;
    item.required_size = req;
    item.release_segment = rel;
    while (pending_q.size() >= 4) @(posedge clk_i);
    pending_q.push_back(item);
  endtask

  // sender holds off until every result is back and the block has settled
  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid_i || expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // mostly allocations sized around the segment, releases aimed at live
  // segments, a little clear, unknown-command and out-of-range noise
  task automatic queue_random();
    logic [1:0]  cmd;
    logic [31:0] req;
    logic [5:0]  rel;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    req = $urandom();
    rel = 6'($urandom_range(0, 63));
    if (roll < 55) begin
      cmd = CmdAlloc;
      case ($urandom_range(0, 9))
        0: ;  // whole 32-bit range
        1: req = 32'(cfg_seg_size);
        2: req = 32'(cfg_seg_size) + 32'd1;
        3: req = '0;
        default: req = $urandom_range(0, 32'(cfg_seg_size >> 2) + 1);
      endcase
    end else if (roll < 97) begin
      cmd = CmdRelease;
      case ($urandom_range(0, 4))
        0, 1: rel = 6'(cur_seg);
        2, 3: rel = 6'($urandom_range(0, used_segments() - 1));
        default: ;
      endcase
    end else if (roll < 99) begin
      cmd = CmdClear;
    end else begin
      cmd = CmdUnknown;
    end
    queue_item(cmd, req, rel);
  endtask

  task automatic run_phase(input logic [31:0] size, input logic [31:0] count);
    write_reg(AddrSegSize, size);
    write_reg(AddrSegCount, count);
    repeat (PhaseItems) queue_random();
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    empty_ring();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset configuration: in-place fit, oversized frame into a fresh segment,
    // release down to zero, double release, release of an empty segment,
    // unknown command, partial release, clear
    queue_item(CmdAlloc, 32'd0, 6'd0);
    queue_item(CmdAlloc, 32'hFFFF_FFFF, 6'd63);
    queue_item(CmdAlloc, 32'd1, 6'd0);
    queue_item(CmdRelease, 32'hFFFF_FFFF, 6'd1);
    queue_item(CmdRelease, 32'd0, 6'd1);
    queue_item(CmdRelease, 32'd0, 6'd63);
    queue_item(CmdUnknown, 32'hFFFF_FFFF, 6'd63);
    queue_item(CmdAlloc, 32'd100, 6'd0);
    queue_item(CmdRelease, 32'd0, 6'd2);
    queue_item(CmdClear, 32'hFFFF_FFFF, 6'd63);
    wait_drained();

    // zero-size segments and a single segment: only empty frames fit in
    // place, no free segment, release past the count
    write_reg(AddrSegSize, 32'd0);
    write_reg(AddrSegCount, 32'd1);
    queue_item(CmdAlloc, 32'd0, 6'd0);
    queue_item(CmdAlloc, 32'd1, 6'd0);
    queue_item(CmdRelease, 32'd0, 6'd1);
    queue_item(CmdRelease, 32'd0, 6'd0);
    queue_item(CmdAlloc, 32'd1, 6'd0);
    wait_drained();

    // largest segment, count of zero behaves as one; an exact fill then a miss
    write_reg(AddrSegSize, 32'hFFFF_FFFF);
    write_reg(AddrSegCount, 32'hFFFF_FF80);
    queue_item(CmdAlloc, 32'h3FFF_FFFE, 6'd0);
    queue_item(CmdAlloc, 32'd1, 6'd0);
    wait_drained();

    // count past the maximum, walk the current segment forward
    write_reg(AddrSegSize, 32'd16);
    write_reg(AddrSegCount, 32'd127);
    queue_item(CmdClear, 32'd0, 6'd0);
    repeat (3) queue_item(CmdAlloc, 32'd17, 6'd0);
    wait_drained();

    // shrink the count under the current segment
    write_reg(AddrSegCount, 32'd2);
    queue_item(CmdAlloc, 32'd0, 6'd0);
    queue_item(CmdRelease, 32'd0, 6'd3);
    wait_drained();

    // random traffic over a spread of settings
    run_phase(32'd64, 32'd4);
    run_phase(32'd1000, 32'd64);
    run_phase(32'd0, 32'd3);
    run_phase(32'd100, 32'd1);
    run_phase(32'hFFFF_FFFF, 32'd127);
    run_phase(32'd4096, 32'd16);
    run_phase(32'd1048576, 32'd0);
    // closing stretch at full throughput on both sides
    idling_on = 1'b0;
    run_phase(32'd256, 32'd8);

    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
